// File: rtl/srh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srh_pkg
// Shared types and constants of the source radius histogrammer: register
// indexes, controller commands and datapath status.
// ----------------------------------------------------------------------------
package srh_pkg;

    // configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_PARAM_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_STEP   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PARAM_COUNT  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_RADIUS_LIMIT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH    = 3'd4;

    // reset values of the registers
    localparam logic [15:0] RST_PARAM_START  = 16'd2048;
    localparam logic [15:0] RST_PARAM_STEP   = 16'd205;
    localparam logic [6:0]  RST_PARAM_COUNT  = 7'd55;
    localparam logic [15:0] RST_RADIUS_LIMIT = 16'd8192;
    localparam logic [15:0] RST_BIN_WIDTH    = 16'd205;

    // iterative divider: 32 bit dividend, 16 bit divisor
    localparam int DIV_NUM_W = 32;
    localparam int DIV_DEN_W = 16;

    // square root unit: radicand below 2^62
    localparam int SQRT_W = 62;

    localparam logic [31:0] COUNT_MAX = 32'hFFFF_FFFF;

    // controller to datapath
    typedef struct packed {
        logic clr_wr;        // write zero at the sweep address, advance
        logic load_item;     // capture the input beat
        logic load_p;        // form the trial scale
        logic start_div_d;   // start offset division
        logic load_mul;      // offset times direction
        logic cand_next;     // move to the second candidate
        logic load_pos;      // candidate coordinates
        logic load_abs;      // magnitudes and box test
        logic load_sq;       // squares
        logic start_sqrt;    // start radius root
        logic start_div_bin; // start bin division
        logic mem_rd;        // histogram read
        logic rd_sel_read;   // read address from the read beat
        logic mem_wr;        // histogram update write
        logic next_trial;    // advance trial counter
        logic load_out;      // load result register
    } srh_cmd_t;

    // datapath to controller
    typedef struct packed {
        logic clr_last;
        logic is_read;
        logic ev_skip;
        logic div_busy;
        logic sqrt_busy;
        logic pos_ok;
        logic bin_ok;
        logic cand1;
        logic last_trial;
        logic out_busy;
    } srh_sts_t;

endpackage
`default_nettype wire

// File: rtl/srh_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srh_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module srh_div (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          start,
    input  wire logic [srh_pkg::DIV_NUM_W-1:0] num,
    input  wire logic [srh_pkg::DIV_DEN_W-1:0] den,
    output logic                               busy,
    output logic [srh_pkg::DIV_NUM_W-1:0]      quo
);
    import srh_pkg::*;

    localparam int CNT_W = $clog2(DIV_NUM_W + 1);

    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DIV_NUM_W-1:0] quo_reg, quo_next;
    logic [DIV_DEN_W-1:0] rem_reg, rem_next;
    logic [DIV_DEN_W-1:0] den_reg, den_next;
    logic [DIV_DEN_W:0]   r_try;
    logic                 ge;

    // one shift-subtract step
    always_comb begin
        r_try    = {rem_reg, quo_reg[DIV_NUM_W-1]};
        ge       = r_try >= {1'b0, den_reg};
        cnt_next = cnt_reg;
        quo_next = quo_reg;
        rem_next = rem_reg;
        den_next = den_reg;
        if (start) begin
            cnt_next = CNT_W'(DIV_NUM_W);
            quo_next = num;
            rem_next = '0;
            den_next = den;
        end else if (cnt_reg != '0) begin
            cnt_next = cnt_reg - 1'b1;
            quo_next = {quo_reg[DIV_NUM_W-2:0], ge};
            rem_next = ge ? DIV_DEN_W'(r_try - {1'b0, den_reg}) : r_try[DIV_DEN_W-1:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else begin
            cnt_reg <= cnt_next;
        end
        quo_reg <= quo_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
    end

    assign busy = cnt_reg != '0;
    assign quo  = quo_reg;

endmodule
`default_nettype wire

// File: rtl/srh_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srh_sqrt
// Integer square root, two radicand bits per cycle.
// ----------------------------------------------------------------------------
module srh_sqrt (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       start,
    input  wire logic [srh_pkg::SQRT_W-1:0] rad,
    output logic                            busy,
    output logic [srh_pkg::SQRT_W-1:0]      root
);
    import srh_pkg::*;

    logic [SQRT_W-1:0] s_reg, s_next;
    logic [SQRT_W-1:0] root_reg, root_next;
    logic [SQRT_W-1:0] bit_reg, bit_next;
    logic [SQRT_W-1:0] trial;

    // bit walks down by powers of four
    always_comb begin
        trial     = root_reg + bit_reg;
        s_next    = s_reg;
        root_next = root_reg;
        bit_next  = bit_reg;
        if (start) begin
            s_next    = rad;
            root_next = '0;
            bit_next  = SQRT_W'(1) << (SQRT_W - 2);
        end else if (bit_reg != '0) begin
            bit_next = bit_reg >> 2;
            if (s_reg >= trial) begin
                s_next    = s_reg - trial;
                root_next = (root_reg >> 1) + bit_reg;
            end else begin
                root_next = root_reg >> 1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bit_reg <= '0;
        end else begin
            bit_reg <= bit_next;
        end
        s_reg    <= s_next;
        root_reg <= root_next;
    end

    assign busy = bit_reg != '0;
    assign root = root_reg;

endmodule
`default_nettype wire

// File: rtl/srh_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srh_datapath
// Registers, arithmetic, histogram memory and result register.
// ----------------------------------------------------------------------------
module srh_datapath #(
    parameter int MAX_TRIALS = 64,
    parameter int NUM_BINS   = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire srh_pkg::srh_cmd_t              cmd,
    output srh_pkg::srh_sts_t                   sts,
    input  wire logic                           cfg_wr_en,
    input  wire logic [srh_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [srh_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                           s_func,
    input  wire logic signed [15:0]             s_center_x,
    input  wire logic signed [15:0]             s_center_y,
    input  wire logic signed [15:0]             s_axis_cos,
    input  wire logic signed [15:0]             s_axis_sin,
    input  wire logic [15:0]                    s_image_width,
    input  wire logic [15:0]                    s_image_length,
    input  wire logic                           s_on_source,
    input  wire logic [5:0]                     s_read_trial,
    input  wire logic [5:0]                     s_read_bin,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [31:0]                         m_on_count,
    output logic [31:0]                         m_off_count,
    output logic signed [32:0]                  m_count_difference,
    output logic [15:0]                         m_trial_value
);
    import srh_pkg::*;

    localparam int DEPTH = MAX_TRIALS * NUM_BINS;
    localparam int AW    = $clog2(DEPTH);
    localparam int TIW   = (MAX_TRIALS > 1) ? $clog2(MAX_TRIALS) : 1;
    localparam int NW    = $clog2(MAX_TRIALS + 1);
    localparam int BINW  = $clog2(NUM_BINS);

    // saturated trial scale start + step * idx
    function automatic logic [15:0] trial_scale(input logic [15:0] st, input logic [15:0] sp,
                                                input logic [8:0] idx);
        logic [24:0] p;
        p = 25'(st) + 25'(sp) * 25'(idx);
        return (p > 25'hFFFF) ? 16'hFFFF : p[15:0];
    endfunction

    // configuration registers
    logic [15:0] start_reg, step_reg, limit_reg, bwid_reg;
    logic [6:0]  count_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            start_reg <= RST_PARAM_START;
            step_reg  <= RST_PARAM_STEP;
            count_reg <= RST_PARAM_COUNT;
            limit_reg <= RST_RADIUS_LIMIT;
            bwid_reg  <= RST_BIN_WIDTH;
        end else if (cfg_wr_en) begin
            case (cfg_wr_index)
                REG_PARAM_START:  start_reg <= cfg_wr_data;
                REG_PARAM_STEP:   step_reg  <= cfg_wr_data;
                REG_PARAM_COUNT:  count_reg <= cfg_wr_data[6:0];
                REG_RADIUS_LIMIT: limit_reg <= cfg_wr_data;
                REG_BIN_WIDTH:    bwid_reg  <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    // captured beat
    logic               func_reg, on_reg, diff_neg_reg;
    logic signed [15:0] xc_reg, yc_reg, cs_reg, sn_reg;
    logic [15:0]        len_reg, adiff_reg;
    logic [5:0]         rtrial_reg, rbin_reg;
    logic [NW-1:0]      n_reg;
    logic [29:0]        lim_reg;
    logic [59:0]        lim2_reg;
    logic [16:0]        ldiff;

    assign ldiff = 17'(s_image_length) - 17'(s_image_width);

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            func_reg     <= s_func;
            on_reg       <= s_on_source;
            xc_reg       <= s_center_x;
            yc_reg       <= s_center_y;
            cs_reg       <= s_axis_cos;
            sn_reg       <= s_axis_sin;
            len_reg      <= s_image_length;
            diff_neg_reg <= ldiff[16];
            adiff_reg    <= ldiff[16] ? 16'(-ldiff) : ldiff[15:0];
            rtrial_reg   <= s_read_trial;
            rbin_reg     <= s_read_bin;
            n_reg        <= (32'(count_reg) > MAX_TRIALS) ? NW'(MAX_TRIALS) : NW'(count_reg);
            lim_reg      <= {limit_reg, 14'd0};
            lim2_reg     <= {32'(limit_reg) * 32'(limit_reg), 28'd0};
        end
    end

    // trial counter and candidate select
    logic [TIW-1:0] trial_reg;
    logic           cand_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            trial_reg <= '0;
        end else if (cmd.next_trial) begin
            trial_reg <= trial_reg + 1'b1;
        end
        if (cmd.load_mul) begin
            cand_reg <= 1'b0;
        end else if (cmd.cand_next) begin
            cand_reg <= 1'b1;
        end
    end

    // shared divider and root unit
    logic                 div_start, div_busy, sqrt_busy;
    logic [DIV_NUM_W-1:0] div_num, quo;
    logic [DIV_DEN_W-1:0] div_den;
    logic [SQRT_W-1:0]    root;
    logic [15:0]          p_reg;
    logic [60:0]          sqx_reg, sqy_reg;
    logic [61:0]          ssum;

    assign ssum      = 62'(sqx_reg) + 62'(sqy_reg);
    assign div_start = cmd.start_div_d | cmd.start_div_bin;

    always_comb begin
        if (cmd.start_div_bin) begin
            div_num = DIV_NUM_W'(root[30:14]);
            div_den = (bwid_reg == '0) ? 16'd1 : bwid_reg;
        end else begin
            div_num = DIV_NUM_W'(32'(p_reg) * 32'(adiff_reg));
            div_den = len_reg;
        end
    end

    srh_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .busy    (div_busy),
        .quo     (quo)
    );

    srh_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.start_sqrt),
        .rad     (ssum),
        .busy    (sqrt_busy),
        .root    (root)
    );

    // candidate arithmetic
    logic signed [48:0] sdx_reg, sdy_reg;
    logic signed [49:0] x_reg, y_reg;
    logic [29:0]        ax_reg, ay_reg;
    logic               lim_ok_reg;
    logic [46:0]        mx, my;
    logic signed [49:0] bx, by;
    logic [49:0]        axw, ayw;

    // direction magnitude taken unsigned so that -32768 gives 32768
    assign mx  = 47'(quo) * 47'($unsigned(cs_reg[15] ? -cs_reg : cs_reg));
    assign my  = 47'(quo) * 47'($unsigned(sn_reg[15] ? -sn_reg : sn_reg));
    assign bx  = 50'(xc_reg) <<< 14;
    assign by  = 50'(yc_reg) <<< 14;
    assign axw = x_reg[49] ? 50'(-x_reg) : 50'(x_reg);
    assign ayw = y_reg[49] ? 50'(-y_reg) : 50'(y_reg);

    always_ff @(posedge aclk) begin
        if (cmd.load_p) begin
            p_reg <= trial_scale(start_reg, step_reg, 9'(trial_reg));
        end
        if (cmd.load_mul) begin
            sdx_reg <= (diff_neg_reg ^ cs_reg[15]) ? -$signed({2'b00, mx}) : $signed({2'b00, mx});
            sdy_reg <= (diff_neg_reg ^ sn_reg[15]) ? -$signed({2'b00, my}) : $signed({2'b00, my});
        end
        if (cmd.load_pos) begin
            x_reg <= cand_reg ? bx + 50'(sdx_reg) : bx - 50'(sdx_reg);
            y_reg <= cand_reg ? by + 50'(sdy_reg) : by - 50'(sdy_reg);
        end
        if (cmd.load_abs) begin
            lim_ok_reg <= (axw < 50'(lim_reg)) && (ayw < 50'(lim_reg));
            ax_reg     <= axw[29:0];
            ay_reg     <= ayw[29:0];
        end
        if (cmd.load_sq) begin
            sqx_reg <= 61'(60'(ax_reg) * 60'(ax_reg));
            sqy_reg <= 61'(60'(ay_reg) * 60'(ay_reg));
        end
    end

    // histogram memory, {on, off} per entry
    logic [63:0]   mem [DEPTH];
    logic [63:0]   rdata_reg, wdata;
    logic [AW-1:0] clr_reg, ev_addr, rd_addr, raddr, waddr;
    logic          we, rd_oob;

    assign ev_addr = AW'(32'(trial_reg) * NUM_BINS + 32'(quo[BINW-1:0]));
    assign rd_addr = AW'(32'(rtrial_reg) * NUM_BINS + 32'(rbin_reg));
    assign rd_oob  = (32'(rtrial_reg) >= MAX_TRIALS) || (32'(rbin_reg) >= NUM_BINS);
    assign raddr   = cmd.rd_sel_read ? rd_addr : ev_addr;
    assign waddr   = cmd.clr_wr ? clr_reg : ev_addr;
    assign we      = cmd.clr_wr | cmd.mem_wr;

    // saturating increment of one half, or zero during the clearing sweep
    always_comb begin
        wdata = rdata_reg;
        if (cmd.clr_wr) begin
            wdata = '0;
        end else if (on_reg) begin
            if (rdata_reg[63:32] != COUNT_MAX) wdata[63:32] = rdata_reg[63:32] + 1'b1;
        end else begin
            if (rdata_reg[31:0] != COUNT_MAX) wdata[31:0] = rdata_reg[31:0] + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (cmd.mem_rd) begin
            rdata_reg <= mem[raddr];
        end
    end

    // clearing sweep address
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_reg <= '0;
        end else if (cmd.clr_wr) begin
            clr_reg <= clr_reg + 1'b1;
        end
    end

    // result register
    logic               m_valid_reg;
    logic [31:0]        on_out_reg, off_out_reg;
    logic signed [32:0] diff_out_reg;
    logic [15:0]        tval_reg;
    logic [31:0]        on_v, off_v;

    assign on_v  = rd_oob ? 32'd0 : rdata_reg[63:32];
    assign off_v = rd_oob ? 32'd0 : rdata_reg[31:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
        if (cmd.load_out) begin
            on_out_reg   <= on_v;
            off_out_reg  <= off_v;
            diff_out_reg <= $signed({1'b0, on_v}) - $signed({1'b0, off_v});
            tval_reg     <= trial_scale(start_reg, step_reg, 9'(rtrial_reg));
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_on_count         = on_out_reg;
    assign m_off_count        = off_out_reg;
    assign m_count_difference = diff_out_reg;
    assign m_trial_value      = tval_reg;

    // status
    always_comb begin
        sts.clr_last   = clr_reg == AW'(DEPTH - 1);
        sts.is_read    = func_reg;
        sts.ev_skip    = (len_reg == '0) || (n_reg == '0);
        sts.div_busy   = div_busy;
        sts.sqrt_busy  = sqrt_busy;
        sts.pos_ok     = lim_ok_reg && (ssum < 62'(lim2_reg));
        sts.bin_ok     = quo < DIV_NUM_W'(NUM_BINS);
        sts.cand1      = cand_reg;
        sts.last_trial = (32'(trial_reg) + 1) == 32'(n_reg);
        sts.out_busy   = m_valid_reg && !m_ready;
    end

    // checks
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy) else $error("divider restarted while busy");
    a_sqrt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start_sqrt |-> !sqrt_busy) else $error("root unit restarted while busy");
    a_rmw: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr |-> $past(cmd.mem_rd) && !$past(cmd.rd_sel_read))
        else $error("update write without its read");
    a_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |-> !(m_valid_reg && !m_ready)) else $error("result overwritten");

endmodule
`default_nettype wire

// File: rtl/srh_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// srh_ctrl
// Sequencer: clearing sweep, read beats and the per-trial event walk.
// ----------------------------------------------------------------------------
module srh_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire srh_pkg::srh_sts_t sts,
    output srh_pkg::srh_cmd_t      cmd
);
    import srh_pkg::*;

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_DISPATCH, ST_RD_MEM, ST_RD_OUT,
        ST_EV_P, ST_EV_DIV, ST_EV_DIVW, ST_EV_MUL, ST_EV_POS, ST_EV_ABS,
        ST_EV_SQ, ST_EV_CHK, ST_EV_SQW, ST_EV_BINW, ST_EV_WR
    } state_t;

    state_t state_reg, state_next;

    // commands and next state
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clr_wr = 1'b1;
                if (sts.clr_last) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load_item = 1'b1;
                    state_next    = ST_DISPATCH;
                end
            end
            ST_DISPATCH: begin
                if (sts.is_read) state_next = ST_RD_MEM;
                else if (sts.ev_skip) state_next = ST_IDLE;
                else state_next = ST_EV_P;
            end
            ST_RD_MEM: begin
                cmd.mem_rd      = 1'b1;
                cmd.rd_sel_read = 1'b1;
                state_next      = ST_RD_OUT;
            end
            ST_RD_OUT: begin
                if (!sts.out_busy) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_EV_P: begin
                cmd.load_p = 1'b1;
                state_next = ST_EV_DIV;
            end
            ST_EV_DIV: begin
                cmd.start_div_d = 1'b1;
                state_next      = ST_EV_DIVW;
            end
            ST_EV_DIVW: begin
                if (!sts.div_busy) state_next = ST_EV_MUL;
            end
            ST_EV_MUL: begin
                cmd.load_mul = 1'b1;
                state_next   = ST_EV_POS;
            end
            ST_EV_POS: begin
                cmd.load_pos = 1'b1;
                state_next   = ST_EV_ABS;
            end
            ST_EV_ABS: begin
                cmd.load_abs = 1'b1;
                state_next   = ST_EV_SQ;
            end
            ST_EV_SQ: begin
                cmd.load_sq = 1'b1;
                state_next  = ST_EV_CHK;
            end
            ST_EV_CHK: begin
                if (sts.pos_ok) begin
                    cmd.start_sqrt = 1'b1;
                    state_next     = ST_EV_SQW;
                end else begin
                    state_next = ST_EV_WR;
                end
            end
            ST_EV_SQW: begin
                if (!sts.sqrt_busy) begin
                    cmd.start_div_bin = 1'b1;
                    state_next        = ST_EV_BINW;
                end
            end
            ST_EV_BINW: begin
                if (!sts.div_busy) begin
                    cmd.mem_rd = sts.bin_ok;
                    state_next = ST_EV_WR;
                end
            end
            // update write (when a read was issued), then next candidate, next trial or idle
            ST_EV_WR: begin
                cmd.mem_wr = sts.pos_ok && sts.bin_ok && !sts.div_busy && !sts.sqrt_busy;
                if (!sts.cand1) begin
                    cmd.cand_next = 1'b1;
                    state_next    = ST_EV_POS;
                end else if (sts.last_trial) begin
                    state_next = ST_IDLE;
                end else begin
                    cmd.next_trial = 1'b1;
                    state_next     = ST_EV_P;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = state_reg == ST_IDLE;

    // checks
    a_no_accept_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_CLEAR |-> !cmd.load_item) else $error("beat taken during sweep");
    a_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_item |=> state_reg == ST_DISPATCH) else $error("capture not dispatched");
    a_wr_after_rd: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.mem_wr |-> $past(state_reg) == ST_EV_BINW) else $error("write out of sequence");

endmodule
`default_nettype wire

// File: rtl/source_radius_histogrammer.sv
`default_nettype none
// Read beat: dispatch, memory read, result load once the result register is free;
// s_ready returns in the same cycle as m_valid. Accumulate beat: per trial the 32-step
// divider (shared by offset and bin division) forms the offset and, per candidate in
// range, the bin after the 31-step square-root unit; zero-length beats and beats with no
// trials in use return to idle from dispatch. Reset: synchronous, active low; a clearing
// pass zeroes all MAX_TRIALS * NUM_BINS entries (4096 by default) before s_ready rises.
// ----------------------------------------------------------------------------
// source_radius_histogrammer
// Fills on/off source-radius histograms for a range of trial scales and reads
// back one trial and bin per read beat.
// ----------------------------------------------------------------------------
module source_radius_histogrammer #(
    parameter int MAX_TRIALS = 64,
    parameter int NUM_BINS   = 64
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_wr_en,
    input  wire logic [srh_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  wire logic [srh_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    input  wire logic                           s_valid,
    output logic                                s_ready,
    input  wire logic                           s_func,
    input  wire logic signed [15:0]             s_center_x,
    input  wire logic signed [15:0]             s_center_y,
    input  wire logic signed [15:0]             s_axis_cos,
    input  wire logic signed [15:0]             s_axis_sin,
    input  wire logic [15:0]                    s_image_width,
    input  wire logic [15:0]                    s_image_length,
    input  wire logic                           s_on_source,
    input  wire logic [5:0]                     s_read_trial,
    input  wire logic [5:0]                     s_read_bin,
    output logic                                m_valid,
    input  wire logic                           m_ready,
    output logic [31:0]                         m_on_count,
    output logic [31:0]                         m_off_count,
    output logic signed [32:0]                  m_count_difference,
    output logic [15:0]                         m_trial_value
);
    import srh_pkg::*;

    srh_cmd_t cmd;
    srh_sts_t sts;

    srh_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    srh_datapath #(
        .MAX_TRIALS (MAX_TRIALS),
        .NUM_BINS   (NUM_BINS)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .sts                (sts),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_wr_index       (cfg_wr_index),
        .cfg_wr_data        (cfg_wr_data),
        .s_func             (s_func),
        .s_center_x         (s_center_x),
        .s_center_y         (s_center_y),
        .s_axis_cos         (s_axis_cos),
        .s_axis_sin         (s_axis_sin),
        .s_image_width      (s_image_width),
        .s_image_length     (s_image_length),
        .s_on_source        (s_on_source),
        .s_read_trial       (s_read_trial),
        .s_read_bin         (s_read_bin),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_on_count         (m_on_count),
        .m_off_count        (m_off_count),
        .m_count_difference (m_count_difference),
        .m_trial_value      (m_trial_value)
    );

endmodule
`default_nettype wire
